// ----- sv/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// Shared widths, command and status codes, and cell control types for the
// circular list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 4;
  localparam int LEN_W  = 5;

  localparam int IN_FIELDS_W  = CMD_W + DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STAT_W + DATA_W + POS_W + LEN_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_BACK  = 3'd3,
    CMD_REM_VALUE = 3'd4,
    CMD_SEARCH    = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE     = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_APPEND     = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_ROTATE     = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic [DATA_W-1:0]       value;
    logic [CNT_W-1:0]        count;
  } cell_ctl_t;

endpackage

// ----- sv/cle_cell.sv -----
// ----------------------------------------------------------------------------
// cle_cell
// One list entry. Shifts toward either neighbor, takes a new value or
// wraps the head around to the tail slot, as the broadcast op says.
// ----------------------------------------------------------------------------
module cle_cell
  import cle_pkg::*;
(
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [CNT_W-1:0]  idx_i,
  input  logic [DATA_W-1:0] left_val_i,
  input  logic [DATA_W-1:0] right_val_i,
  input  logic [DATA_W-1:0] head_val_i,
  output logic [DATA_W-1:0] val_o
);

  logic [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  last_idx;

  assign last_idx = ctl_i.count - CNT_W'(1);

  always_comb begin
    val_d = val_q;
    unique case (ctl_i.op)
      OP_HOLD:       val_d = val_q;
      OP_PUSH_FRONT: val_d = (idx_i == '0) ? ctl_i.value : left_val_i;
      OP_APPEND:     val_d = (idx_i == ctl_i.count) ? ctl_i.value : val_q;
      OP_POP_FRONT:  val_d = right_val_i;
      OP_ROTATE:     val_d = (idx_i == last_idx) ? head_val_i : right_val_i;
      default:       val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ----- sv/cle_seq.sv -----
// ----------------------------------------------------------------------------
// cle_seq
// Command sequencer: decodes transactions, keeps the entry count, drives
// the cell row and walks the ring for search and remove-by-value.
// ----------------------------------------------------------------------------
module cle_seq
  import cle_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic [DATA_W-1:0]      head_val_i,
  input  logic [DATA_W-1:0]      tail_val_i,
  output cell_ctl_t              ctl_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_REPLY = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  step_q, step_d;
  logic [CNT_W-1:0]  span_q, span_d;
  logic              found_q, found_d;
  logic              is_rem_q, is_rem_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_stat_q, out_stat_d;
  logic [DATA_W-1:0] out_val_q, out_val_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;

  logic              out_free, accept, match;
  cmd_e              in_cmd;
  logic [DATA_W-1:0] in_val;

  assign in_cmd   = cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
  assign in_val   = s_axis_tdata_i[CMD_W +: DATA_W];
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign match    = (head_val_i == key_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    span_d      = span_q;
    found_d     = found_q;
    is_rem_d    = is_rem_q;
    key_d       = key_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_stat_d  = out_stat_q;
    out_val_d   = out_val_q;
    out_pos_d   = out_pos_q;
    out_len_d   = out_len_q;
    ctl_o.op    = OP_HOLD;
    ctl_o.value = in_val;
    ctl_o.count = cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_stat_d = STAT_DONE;
          out_val_d  = '0;
          out_pos_d  = '0;
          out_len_d  = LEN_W'(cnt_q);
          case (in_cmd) inside
            CMD_INS_FRONT, CMD_INS_BACK: begin
              out_valid_d = 1'b1;
              if (cnt_q == CNT_W'(CAPACITY)) begin
                out_stat_d = STAT_FULL;
              end else begin
                ctl_o.op  = (in_cmd == CMD_INS_FRONT) ? OP_PUSH_FRONT : OP_APPEND;
                cnt_d     = cnt_q + CNT_W'(1);
                out_len_d = LEN_W'(cnt_q + CNT_W'(1));
              end
            end
            CMD_REM_FRONT, CMD_REM_BACK: begin
              out_valid_d = 1'b1;
              if (cnt_q == '0) begin
                out_stat_d = STAT_EMPTY;
              end else begin
                if (in_cmd == CMD_REM_FRONT) begin
                  ctl_o.op  = OP_POP_FRONT;
                  out_val_d = head_val_i;
                end else begin
                  out_val_d = tail_val_i;
                end
                cnt_d     = cnt_q - CNT_W'(1);
                out_len_d = LEN_W'(cnt_q - CNT_W'(1));
              end
            end
            CMD_REM_VALUE, CMD_SEARCH: begin
              if (cnt_q == '0) begin
                out_valid_d = 1'b1;
                out_stat_d  = STAT_EMPTY;
              end else begin
                state_d  = ST_WALK;
                step_d   = '0;
                span_d   = cnt_q;
                found_d  = 1'b0;
                is_rem_d = (in_cmd == CMD_REM_VALUE);
                key_d    = in_val;
                pos_d    = '0;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (is_rem_q && match && !found_q) begin
          ctl_o.op = OP_POP_FRONT;
          cnt_d    = cnt_q - CNT_W'(1);
          found_d  = 1'b1;
        end else begin
          ctl_o.op = OP_ROTATE;
          if (!is_rem_q && match && !found_q) begin
            found_d = 1'b1;
            pos_d   = POS_W'(step_q);
          end
        end
        step_d = step_q + CNT_W'(1);
        if (step_q == span_q - CNT_W'(1)) begin
          state_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_stat_d  = found_q ? STAT_DONE : STAT_NOTFOUND;
          out_val_d   = '0;
          out_pos_d   = pos_q;
          out_len_d   = LEN_W'(cnt_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    span_q     <= span_d;
    found_q    <= found_d;
    is_rem_q   <= is_rem_d;
    key_q      <= key_d;
    pos_q      <= pos_d;
    out_stat_q <= out_stat_d;
    out_val_q  <= out_val_d;
    out_pos_q  <= out_pos_d;
    out_len_q  <= out_len_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_len_q, out_pos_q, out_val_q, out_stat_q};

endmodule

// ----- sv/circular_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// circular_list_engine_top
// Ordered circular list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one command per transaction (insert front/back,
//   remove front/back, remove value, search) with its operand. Output
//   stream returns one result per command: status, removed value, search
//   position and list length after the command.
//   List entries sit in order in a row of cells, cell 0 holding the front.
//   Inserts and removes at either end need no ring walk: the result is
//   registered and shown the cycle after the transaction.
//   Search and remove-value rotate the ring through the cell row, one entry
//   compared against cell 0 per cycle, once round the whole list, then the
//   result is posted from the reply state once the output register is free.
//   One command is in work at a time; a new one is taken once the output
//   register is free or being drained in the same cycle.
//   Reset empties the list at once. A stalled receiver holds the result
//   and blocks further commands until it is taken.
// ----------------------------------------------------------------------------
module circular_list_engine_top
  import cle_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // cmd [2:0], value [34:3], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // status [1:0], out_value [33:2], position [37:34], length [42:38], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  cell_ctl_t         ctl;
  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [DATA_W-1:0] tail_val;
  logic [IDX_W-1:0]  tail_idx;

  assign tail_idx = IDX_W'(ctl.count - CNT_W'(1));
  assign tail_val = cell_val[tail_idx];

  cle_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .head_val_i      (cell_val[0]),
    .tail_val_i      (tail_val),
    .ctl_o           (ctl)
  );

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [DATA_W-1:0] left_val, right_val;
    if (j == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[0];
    end else begin : g_mid_r
      assign right_val = cell_val[j+1];
    end
    cle_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .idx_i       (CNT_W'(j)),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .head_val_i  (cell_val[0]),
      .val_o       (cell_val[j])
    );
  end

endmodule

// ----- sv/cle_checker.sv -----
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks on the result stream of the circular list engine.
// ----------------------------------------------------------------------------
module cle_checker
  import cle_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic [STAT_W-1:0] stat;
  logic [DATA_W-1:0] oval;
  logic [LEN_W-1:0]  len;

  assign stat = m_axis_tdata_o[STAT_W-1:0];
  assign oval = m_axis_tdata_o[STAT_W +: DATA_W];
  assign len  = m_axis_tdata_o[STAT_W + DATA_W + POS_W +: LEN_W];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> len <= LEN_W'(CAPACITY))
    else $error("length above capacity");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && stat == STAT_FULL |-> len == LEN_W'(CAPACITY))
    else $error("full reported on a list that is not full");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && stat == STAT_EMPTY |-> len == '0)
    else $error("empty reported on a nonempty list");

  a_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && oval != '0 |-> stat == STAT_DONE)
    else $error("removed value with a failing status");

endmodule

bind circular_list_engine_top cle_checker u_cle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_list_engine_top. A queue-based model of
// the list predicts status, removed value, search position and length for
// every accepted command; each output transaction is checked field by field
// against the oldest prediction. Directed end cases and a long output hold-off
// come first, then random fill, drain, mixed and noise sequences under random
// stalls on both streams (none in a middle stretch) and a full drain pause.
// ----------------------------------------------------------------------------
module tb;
  import cle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1000;
  localparam int SETTLE_CYCLES = 2 * (CAPACITY + 1) + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  localparam logic [CMD_W-1:0]  CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_UNUSED_B = 3'd7;
  localparam logic [DATA_W-1:0] VALUE_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] VALUE_MAX    = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] out_value;
    logic [POS_W-1:0]  position;
    logic [LEN_W-1:0]  length;
  } list_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  logic [DATA_W-1:0] list_model[$];
  list_result_t      expected_results[$];
  logic [DATA_W-1:0] operand_pool[8];

  list_result_t want_result;
  list_result_t got_result;
  int           error_count;
  int           commands_accepted;
  int           deepest_list;
  int           status_seen[4];
  int           rx_hold_cycles;
  bit           gaps_on;
  bit           rx_idle_on;

  circular_list_engine_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout at %0t with %0d results pending", $time, expected_results.size());
    $display("[circular_list_engine_top] ERROR");
    $finish;
  end

  function automatic list_result_t predict_result(logic [CMD_W-1:0] cmd,
                                                  logic [DATA_W-1:0] operand);
    list_result_t r;
    int           hit;
    r        = '0;
    r.status = STAT_DONE;
    hit      = -1;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (list_model.size() >= CAPACITY) r.status = STAT_FULL;
        else if (cmd == CMD_INS_FRONT) list_model.push_front(operand);
        else list_model.push_back(operand);
      end
      CMD_REM_FRONT, CMD_REM_BACK: begin
        if (list_model.size() == 0) r.status = STAT_EMPTY;
        else if (cmd == CMD_REM_FRONT) r.out_value = list_model.pop_front();
        else r.out_value = list_model.pop_back();
      end
      CMD_REM_VALUE, CMD_SEARCH: begin
        if (list_model.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < list_model.size(); i++)
            if (hit < 0 && list_model[i] == operand) hit = i;
          if (hit < 0) r.status = STAT_NOTFOUND;
          else if (cmd == CMD_REM_VALUE) list_model.delete(hit);
          else r.position = POS_W'(hit);
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(list_model.size());
    return r;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // outputs retire before the input of the same edge is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_result.status    = m_axis_tdata_o[STAT_W-1:0];
        got_result.out_value = m_axis_tdata_o[STAT_W +: DATA_W];
        got_result.position  = m_axis_tdata_o[STAT_W+DATA_W +: POS_W];
        got_result.length    = m_axis_tdata_o[STAT_W+DATA_W+POS_W +: LEN_W];
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected transaction, expected none actual %h", $time,
                   m_axis_tdata_o);
        end else begin
          want_result = expected_results.pop_front();
          status_seen[want_result.status]++;
          check_field("status", DATA_W'(want_result.status), DATA_W'(got_result.status));
          check_field("out_value", want_result.out_value, got_result.out_value);
          check_field("position", DATA_W'(want_result.position),
                      DATA_W'(got_result.position));
          check_field("length", DATA_W'(want_result.length), DATA_W'(got_result.length));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_results.push_back(predict_result(s_axis_tdata_i[CMD_W-1:0],
                                                  s_axis_tdata_i[CMD_W +: DATA_W]));
        commands_accepted++;
        if (list_model.size() > deepest_list) deepest_list = list_model.size();
      end
    end
  end

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        rx_hold_cycles--;
      end else if (!rx_idle_on) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= 35);
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] operand);
    logic [IN_TDATA_W-1:0] word;
    int                    idle;
    if (gaps_on && $urandom_range(99) < 35) begin
      idle = ($urandom_range(19) == 0) ? $urandom_range(2, 25) : $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    word                  = '0;
    word[CMD_W-1:0]       = cmd;
    word[CMD_W +: DATA_W] = operand;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    if (list_model.size() != 0 && $urandom_range(99) < 40)
      return list_model[$urandom_range(0, list_model.size() - 1)];
    if ($urandom_range(99) < 60) return operand_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic test_empty_list();
    send_command(CMD_REM_FRONT, '0);
    send_command(CMD_REM_BACK, VALUE_MAX);
    send_command(CMD_REM_VALUE, '0);
    send_command(CMD_SEARCH, VALUE_MIN);
    send_command(CMD_UNUSED_A, '1);
    send_command(CMD_UNUSED_B, VALUE_MIN);
  endtask

  task automatic test_end_operations();
    send_command(CMD_INS_BACK, '0);
    send_command(CMD_INS_FRONT, VALUE_MIN);
    send_command(CMD_INS_BACK, VALUE_MAX);
    send_command(CMD_INS_BACK, '1);
    send_command(CMD_INS_BACK, '0);
    send_command(CMD_SEARCH, VALUE_MIN);
    send_command(CMD_SEARCH, '1);
    send_command(CMD_SEARCH, 32'd1);
    send_command(CMD_REM_VALUE, 32'd12345);
    send_command(CMD_REM_VALUE, '0);
    send_command(CMD_SEARCH, '0);
    send_command(CMD_UNUSED_B, '1);
    send_command(CMD_REM_FRONT, '0);
    send_command(CMD_REM_BACK, '0);
    send_command(CMD_REM_VALUE, '1);
    send_command(CMD_REM_FRONT, '0);
    drain_and_settle();
  endtask

  // hold the output long enough that the engine backs up onto its input
  task automatic test_output_backpressure();
    rx_hold_cycles = HOLD_CYCLES;
    repeat (12) send_command(cmd_e'($urandom_range(CMD_INS_FRONT, CMD_SEARCH)), pick_operand());
    drain_and_settle();
    repeat (6) send_command(cmd_e'($urandom_range(CMD_INS_FRONT, CMD_SEARCH)), pick_operand());
    drain_and_settle();
  endtask

  task automatic test_random_sequences();
    int issued;
    int shape;
    int n;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      gaps_on    = !(issued >= RANDOM_ITEMS / 3 && issued < RANDOM_ITEMS / 2);
      rx_idle_on = gaps_on;
      shape      = $urandom_range(0, 9);
      if (shape < 3) begin
        n = CAPACITY - list_model.size() + $urandom_range(1, 3);
        repeat (n)
          send_command($urandom_range(1) ? CMD_INS_FRONT : CMD_INS_BACK, pick_operand());
      end else if (shape < 5) begin
        n = list_model.size() + $urandom_range(1, 2);
        repeat (n)
          send_command(cmd_e'($urandom_range(CMD_REM_FRONT, CMD_REM_VALUE)), pick_operand());
      end else if (shape < 9) begin
        n = $urandom_range(5, 25);
        repeat (n)
          send_command(cmd_e'($urandom_range(CMD_INS_FRONT, CMD_SEARCH)), pick_operand());
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_command(CMD_W'($urandom_range(0, (1 << CMD_W) - 1)), $urandom);
      end
      issued += n;
    end
    gaps_on    = 1'b1;
    rx_idle_on = 1'b1;
    drain_and_settle();
  endtask

  initial begin
    rst_ni            = 1'b0;
    s_axis_tvalid_i   = 1'b0;
    s_axis_tdata_i    = '0;
    error_count       = 0;
    commands_accepted = 0;
    deepest_list      = 0;
    status_seen       = '{default: 0};
    rx_hold_cycles    = 0;
    gaps_on           = 1'b1;
    rx_idle_on        = 1'b1;
    operand_pool      = '{VALUE_MIN, VALUE_MAX, '0, '1, 32'd1, $urandom, $urandom, $urandom};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_end_operations();
    test_output_backpressure();
    test_random_sequences();

    $display("Covered %0d commands, list depth up to %0d of %0d entries", commands_accepted,
             deepest_list, CAPACITY);
    $display("Results: %0d done, %0d empty, %0d full, %0d not found", status_seen[STAT_DONE],
             status_seen[STAT_EMPTY], status_seen[STAT_FULL], status_seen[STAT_NOTFOUND]);
    if (error_count == 0) begin
      $display("[circular_list_engine_top] OK");
    end else begin
      $display("[circular_list_engine_top] ERROR");
    end
    $finish;
  end

endmodule
